// ----- rtl/dle_framed_packet_parser_ack_unit_defines.svh -----
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef DLE_FRAMED_PACKET_PARSER_ACK_UNIT_DEFINES_SVH
`define DLE_FRAMED_PACKET_PARSER_ACK_UNIT_DEFINES_SVH

// plain property that must hold at every edge out of reset
`define DFPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition at one edge implies consequence at the next edge
`define DFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dfpa_pkg.sv -----
`timescale 1ns / 1ps

package dfpa_pkg;

    localparam logic [7:0] BYTE_DLE   = 8'h0B;
    localparam logic [7:0] BYTE_START = 8'h02;
    localparam logic [7:0] BYTE_END   = 8'h03;
    localparam logic [7:0] BYTE_ACK   = 8'h07;
    localparam logic [7:0] BYTE_NAK   = 8'h08;

    localparam int REPLY_LEN  = 5;
    localparam int IDX_W      = 3;
    localparam int DESC_DEPTH = 2;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_START   = 4'd1,
        PH_TARGET  = 4'd2,
        PH_COMMAND = 4'd3,
        PH_SIZE    = 4'd4,
        PH_DATA    = 4'd5,
        PH_CK1     = 4'd6,
        PH_CK2     = 4'd7,
        PH_EDLE    = 4'd8,
        PH_EEND    = 4'd9
    } phase_t;

    // one pending reply, handed from the parser to the reply sequencer
    typedef struct packed {
        logic       nak;
        logic [7:0] target;
        logic [7:0] command;
    } reply_t;

    function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] idx, input logic nak);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = BYTE_DLE;
            3'd1:    b = BYTE_START;
            3'd2:    b = nak ? BYTE_NAK : BYTE_ACK;
            3'd3:    b = BYTE_DLE;
            3'd4:    b = BYTE_END;
            default: b = BYTE_END;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/dfpa_front.sv -----
`timescale 1ns / 1ps

module dfpa_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  logic                push,
    output logic                full,
    input  logic                q_full,
    output logic                q_wr,
    output dfpa_pkg::reply_t    q_data
);

    dfpa_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       target_reg, target_next;
    logic [7:0]       command_reg, command_next;
    logic             nak_reg, nak_next;
    logic             accept;
    logic [7:0]       left_dec;

    // only the end byte needs room in the reply queue
    assign full     = (phase_reg == dfpa_pkg::PH_EEND) && q_full;
    assign accept   = push && !full;
    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                dfpa_pkg::PH_START:
                    phase_next = (rx_byte == dfpa_pkg::BYTE_START) ?
                                 dfpa_pkg::PH_TARGET : dfpa_pkg::PH_HUNT;
                dfpa_pkg::PH_TARGET:  phase_next = dfpa_pkg::PH_COMMAND;
                dfpa_pkg::PH_COMMAND: phase_next = dfpa_pkg::PH_SIZE;
                dfpa_pkg::PH_SIZE:
                    phase_next = (rx_byte == 8'd0) ? dfpa_pkg::PH_CK1 : dfpa_pkg::PH_DATA;
                dfpa_pkg::PH_DATA:
                    phase_next = (left_dec == 8'd0) ? dfpa_pkg::PH_CK1 : dfpa_pkg::PH_DATA;
                dfpa_pkg::PH_CK1:     phase_next = dfpa_pkg::PH_CK2;
                dfpa_pkg::PH_CK2:     phase_next = dfpa_pkg::PH_EDLE;
                dfpa_pkg::PH_EDLE:    phase_next = dfpa_pkg::PH_EEND;
                dfpa_pkg::PH_EEND:    phase_next = dfpa_pkg::PH_HUNT;
                default:
                    phase_next = (rx_byte == dfpa_pkg::BYTE_DLE) ?
                                 dfpa_pkg::PH_START : dfpa_pkg::PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        left_next      = left_reg;
        target_next    = target_reg;
        command_next   = command_reg;
        nak_next       = nak_reg;
        q_wr           = 1'b0;
        q_data.nak     = nak_reg || (rx_byte != dfpa_pkg::BYTE_END);
        q_data.target  = target_reg;
        q_data.command = command_reg;
        if (accept)
        begin
            unique case (phase_reg)
                dfpa_pkg::PH_TARGET:  target_next  = rx_byte;
                dfpa_pkg::PH_COMMAND: command_next = rx_byte;
                dfpa_pkg::PH_SIZE:    left_next    = rx_byte;
                dfpa_pkg::PH_DATA:    left_next    = left_dec;
                dfpa_pkg::PH_EDLE:    nak_next     = (rx_byte != dfpa_pkg::BYTE_DLE);
                dfpa_pkg::PH_EEND:
                begin
                    q_wr     = 1'b1;
                    nak_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dfpa_pkg::PH_HUNT;
            left_reg    <= 8'd0;
            target_reg  <= 8'd0;
            command_reg <= 8'd0;
            nak_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            target_reg  <= target_next;
            command_reg <= command_next;
            nak_reg     <= nak_next;
        end
    end

endmodule

// ----- rtl/dfpa_queue.sv -----
`timescale 1ns / 1ps

`include "dle_framed_packet_parser_ack_unit_defines.svh"

module dfpa_queue
#(
    parameter int DEPTH = dfpa_pkg::DESC_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  dfpa_pkg::reply_t    wr_data,
    output logic                full,
    input  logic                rd,
    output dfpa_pkg::reply_t    rd_data,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dfpa_pkg::reply_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({wr, rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DFPA_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "reply queue count past depth")
    `DFPA_ASSERT(a_no_overrun, !(wr && full), "reply written into a full queue")
    `DFPA_ASSERT(a_no_underrun, !(rd && empty), "reply read from an empty queue")

endmodule

// ----- rtl/dfpa_back.sv -----
`timescale 1ns / 1ps

`include "dle_framed_packet_parser_ack_unit_defines.svh"

module dfpa_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  dfpa_pkg::reply_t    q_data,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          tx_byte,
    output logic                last_byte,
    output logic                is_nak,
    output logic [7:0]          pkt_target,
    output logic [7:0]          pkt_command
);

    localparam logic [dfpa_pkg::IDX_W-1:0] LAST_IDX = dfpa_pkg::IDX_W'(dfpa_pkg::REPLY_LEN - 1);

    logic                           busy_reg, busy_next;
    logic [dfpa_pkg::IDX_W-1:0]     idx_reg, idx_next;
    dfpa_pkg::reply_t               desc_reg, desc_next;
    logic                           done;

    assign empty       = !busy_reg;
    assign last_byte   = (idx_reg == LAST_IDX);
    assign tx_byte     = dfpa_pkg::reply_byte(idx_reg, desc_reg.nak);
    assign is_nak      = desc_reg.nak;
    assign pkt_target  = desc_reg.target;
    assign pkt_command = desc_reg.command;

    // current reply finished or none loaded: pull the next one straight in
    assign done = !busy_reg || (pop && last_byte);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        desc_next = desc_reg;
        q_rd      = 1'b0;
        if (done)
        begin
            if (!q_empty)
            begin
                q_rd      = 1'b1;
                busy_next = 1'b1;
                idx_next  = '0;
                desc_next = q_data;
            end
            else
                busy_next = 1'b0;
        end
        else if (pop)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    `DFPA_ASSERT(a_idx_range, idx_reg <= LAST_IDX, "reply byte index out of range")
    `DFPA_ASSERT_NEXT(a_drain, pop && busy_reg && last_byte && q_empty, empty,
        "sequencer busy after final byte with no reply queued")
    `DFPA_ASSERT_NEXT(a_step, pop && busy_reg && !last_byte,
        idx_reg == $past(idx_reg) + 1'b1, "reply byte index did not advance on pop")

endmodule

// ----- rtl/dle_framed_packet_parser_ack_unit.sv -----
`timescale 1ns / 1ps

// dle framed packet parser with ack/nak reply
//
// input side is a queue: drive rx_byte and push; an item goes in at each edge
// with push high and full low. one received byte per item, one per cycle.
// full only rises while the parser waits on the end byte of a packet and the
// reply queue (DESC_DEPTH entries) has no room.
// output side is a queue: while empty is low the oldest reply byte sits on
// tx_byte, last_byte, is_nak, pkt_target and pkt_command; it goes out at each
// edge with pop high. every complete packet yields five items, dle start
// ack/nak dle end, the last one flagged by last_byte.
// the first reply byte is written to the reply queue when the end byte is taken
// and shows once the sequencer has loaded it; reply bytes then leave at one per
// cycle while pop stays high, limited by the single byte sequencer.
// when the receiver stalls, replies pile up in the queue and parsing of the
// following packet goes on until its own end byte finds the queue full.
// reset clears the parser to hunting for dle and drops all queued replies.

module dle_framed_packet_parser_ack_unit
#(
    parameter int DESC_DEPTH = dfpa_pkg::DESC_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        push,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  tx_byte,
    output logic        last_byte,
    output logic        is_nak,
    output logic [7:0]  pkt_target,
    output logic [7:0]  pkt_command
);

    logic               q_wr;
    logic               q_full;
    logic               q_rd;
    logic               q_empty;
    dfpa_pkg::reply_t   q_wr_data;
    dfpa_pkg::reply_t   q_rd_data;

    dfpa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx_byte),
        .push    (push),
        .full    (full),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_data  (q_wr_data)
    );

    dfpa_queue
    #(
        .DEPTH (DESC_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    dfpa_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rd_data),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .tx_byte     (tx_byte),
        .last_byte   (last_byte),
        .is_nak      (is_nak),
        .pkt_target  (pkt_target),
        .pkt_command (pkt_command)
    );

endmodule
